// File: design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Event kinds, the event word passed between front and back, the
// configuration write word, register indexes and reset values.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Defaults of the top level parameters
  localparam int BUTTONS_DEF     = 8;
  localparam int COMBOS_DEF      = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int LEVEL_W    = 8;
  localparam int MASK_W     = 8;
  localparam int LONG_W     = 16;
  localparam int BCOUNT_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EV_IDX_W   = 3;

  // Number of combo slot registers and ticks a member may join a combo
  localparam int SLOT_REGS    = 4;
  localparam int COMBO_WINDOW = 4;

  // Depth of the event queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_D      = 3'd5;

  // Register reset values
  localparam logic [LONG_W-1:0]   LONG_TICKS_RST   = 16'd33;
  localparam logic [BCOUNT_W-1:0] BUTTON_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_LONG  = 2'd1,
    EV_COMBO = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e           kind;
    logic [EV_IDX_W-1:0]   index;
    logic                  last;
  } event_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: design/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier: debounced short, long and combo press detector
// One scan tick in, zero or more press events out, the last one flagged.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] pressed_levels
//  m_axis    out  tvalid/tready         tdata[2:0] event_index, tuser[1:0]
//                                       event_kind, tlast last_event
//  cfg       in   cfg_valid/cfg_ready   cfg_index (register), cfg_data
//
//  A tick passes the accept state, one walk step per button in use (at most
//  BUTTONS), a step to close the walk, the combo check and the release of
//  the final event.
//  Reset clears all button state, the accumulator and the queue at once.
//  A full event queue stalls the walker; the output register keeps one word
//  ready while the master side stalls. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module button_press_classifier #(
  parameter int BUTTONS     = bpc_pkg::BUTTONS_DEF,
  parameter int COMBOS      = bpc_pkg::COMBOS_DEF,
  parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata_i: [7:0] pressed_levels
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,
  // m_axis_tdata_o: [2:0] event_index, [7:3] zero
  // m_axis_tuser_o: [1:0] event_kind
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,
  output logic [1:0]                      m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bpc_pkg::*;

  cfg_wr_t cfg;
  logic    push_valid;
  logic    push_ready;
  event_t  push_data;
  logic    q_valid;
  logic    q_pop;
  event_t  q_data;
  event_t  out_data;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  bpc_front #(
    .BUTTONS     (BUTTONS),
    .COMBOS      (COMBOS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .tick_valid_i  (s_axis_tvalid_i),
    .tick_ready_o  (s_axis_tready_o),
    .tick_levels_i (s_axis_tdata_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  bpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_data)
  );

  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data)
  );

  // Pack the event word onto the stream fields
  assign m_axis_tdata_o = {5'b0, out_data.index};
  assign m_axis_tuser_o = out_data.kind;
  assign m_axis_tlast_o = out_data.last;

endmodule

// File: design/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: scan tick walker and classifier
// Accepts one scan tick, walks the buttons in use one per cycle, stalling
// on a full queue, through debounce, hold counting and combo accumulation,
// then checks the combo slots. Held one deep, a tick's final event gets tlast.
// ----------------------------------------------------------------------------
module bpc_front #(
  parameter int BUTTONS     = bpc_pkg::BUTTONS_DEF,
  parameter int COMBOS      = bpc_pkg::COMBOS_DEF,
  parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpc_pkg::cfg_wr_t             cfg_i,
  input  logic                         tick_valid_i,
  output logic                         tick_ready_o,
  input  logic [bpc_pkg::LEVEL_W-1:0]  tick_levels_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output bpc_pkg::event_t              push_data_o
);
  import bpc_pkg::*;

  localparam int IDXW  = $clog2(BUTTONS);
  localparam int CW    = $clog2(BUTTONS + 1);
  localparam int SLOTS = (COMBOS < SLOT_REGS) ? COMBOS : SLOT_REGS;
  localparam int MW    = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMBO,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEN = 2'd1,
    PH_CONF = 2'd2
  } phase_e;

  // Configuration
  logic [LONG_W-1:0]   long_ticks_q;
  logic [BCOUNT_W-1:0] button_count_q;
  logic [MASK_W-1:0]   combo_mask_q [SLOT_REGS];

  // Per button state
  phase_e                 phase_q [BUTTONS];
  logic [COUNT_WIDTH-1:0] hold_q  [BUTTONS];
  logic [BUTTONS-1:0]     fired_q;
  logic [BUTTONS-1:0]     ready_q;
  logic [BUTTONS-1:0]     cons_q;
  logic [MASK_W-1:0]      accum_q;

  // Walk control
  state_e             state_q;
  logic [CW-1:0]      idx_q;
  logic [LEVEL_W-1:0] lv_q;
  logic               pend_v_q;
  event_t             pend_q;

  // Derived per button views
  logic [MASK_W-1:0]  members;
  logic [BUTTONS-1:0] lv_b;
  logic [BUTTONS-1:0] mem_b;
  logic [BUTTONS-1:0] acc_b;
  logic [CW-1:0]      used;
  logic [IDXW-1:0]    sel;
  logic               walk_live;

  // Step results
  phase_e                 cur_ph;
  logic [COUNT_WIDTH-1:0] cur_hold;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   down;
  phase_e                 ph_n;
  logic [COUNT_WIDTH-1:0] hold_n;
  logic                   fired_n;
  logic                   ready_n;
  logic                   cons_n;
  logic [MASK_W-1:0]      accum_n;
  logic                   ev_valid;
  event_t                 ev;
  logic                   step_ok;
  logic                   hit;
  logic [EV_IDX_W-1:0]    hit_slot;

  // Gather combo members over the slots in use
  always_comb begin
    members = '0;
    for (int s = 0; s < SLOTS; s++) begin
      members = members | combo_mask_q[s];
    end
  end

  // Map level, member and accumulator bits onto button indexes
  for (genvar g = 0; g < BUTTONS; g++) begin : g_bits
    if (g < LEVEL_W) begin : g_low
      assign lv_b[g]  = lv_q[g];
      assign mem_b[g] = members[g];
      assign acc_b[g] = accum_q[g];
    end else begin : g_high
      assign lv_b[g]  = 1'b0;
      assign mem_b[g] = 1'b0;
      assign acc_b[g] = 1'b0;
    end
  end

  // Clamp the button count to the buttons built
  always_comb begin
    if (int'(button_count_q) > BUTTONS) begin
      used = CW'(BUTTONS);
    end else begin
      used = CW'(button_count_q);
    end
  end

  assign sel       = idx_q[IDXW-1:0];
  assign walk_live = (state_q == ST_WALK) && (idx_q < used);

  // Classify the current button
  always_comb begin
    cur_ph   = phase_q[sel];
    cur_hold = hold_q[sel];
    down     = lv_b[sel];
    hold_inc = (cur_hold == '1) ? cur_hold : cur_hold + 1'b1;
    ph_n     = cur_ph;
    hold_n   = cur_hold;
    fired_n  = fired_q[sel];
    ready_n  = ready_q[sel];
    cons_n   = cons_q[sel];
    accum_n  = accum_q;
    ev_valid = 1'b0;
    ev.kind  = EV_SHORT;
    ev.index = EV_IDX_W'(sel);
    ev.last  = 1'b0;
    case (cur_ph)
      PH_SEEN: begin
        ph_n = down ? PH_CONF : PH_IDLE;
      end
      PH_CONF: begin
        if (down) begin
          hold_n = hold_inc;
          if (mem_b[sel] && (hold_inc < COUNT_WIDTH'(COMBO_WINDOW))) begin
            if (!ready_q[sel]) begin
              for (int k = 0; k < MASK_W; k++) begin
                if (int'(sel) == k) accum_n[k] = 1'b1;
              end
              ready_n = 1'b1;
            end
          end else if ((MW'(hold_inc) > MW'(long_ticks_q)) && !fired_q[sel]) begin
            fired_n  = 1'b1;
            ev_valid = 1'b1;
            ev.kind  = EV_LONG;
          end
        end else begin
          if ((MW'(cur_hold) < MW'(long_ticks_q)) && !cons_q[sel]) begin
            ev_valid = 1'b1;
            ev.kind  = EV_SHORT;
          end
          fired_n = 1'b0;
          ph_n    = PH_IDLE;
          hold_n  = '0;
          accum_n = '0;
          ready_n = 1'b0;
          cons_n  = 1'b0;
        end
      end
      default: begin
        if (down) ph_n = PH_SEEN;
      end
    endcase

    // Find the first used slot that equals the accumulator
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit && (combo_mask_q[s] != '0) && (combo_mask_q[s] == accum_q)) begin
        hit      = 1'b1;
        hit_slot = EV_IDX_W'(s);
      end
    end

    if (state_q == ST_COMBO) begin
      ev_valid = (accum_q != '0) && hit;
      ev.kind  = EV_COMBO;
      ev.index = hit_slot;
    end else if (!walk_live) begin
      ev_valid = 1'b0;
    end
  end

  // A new event displaces the held one into the queue
  assign step_ok      = !(ev_valid && pend_v_q && !push_ready_i);
  assign tick_ready_o = (state_q == ST_IDLE);

  always_comb begin
    push_valid_o = 1'b0;
    push_data_o  = pend_q;
    if (state_q == ST_FLUSH) begin
      push_valid_o     = pend_v_q;
      push_data_o.last = 1'b1;
    end else begin
      push_valid_o     = ev_valid && pend_v_q;
      push_data_o.last = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q   <= LONG_TICKS_RST;
      button_count_q <= BUTTON_COUNT_RST;
      for (int s = 0; s < SLOT_REGS; s++) combo_mask_q[s] <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_LONG_TICKS) begin
        long_ticks_q <= cfg_i.data;
      end else if (cfg_i.index == REG_BUTTON_COUNT) begin
        button_count_q <= cfg_i.data[BCOUNT_W-1:0];
      end else if ((cfg_i.index >= REG_COMBO_A) && (cfg_i.index <= REG_COMBO_D)) begin
        for (int s = 0; s < SLOT_REGS; s++) begin
          if (int'(cfg_i.index) - int'(REG_COMBO_A) == s) begin
            combo_mask_q[s] <= cfg_i.data[MASK_W-1:0];
          end
        end
      end
    end
  end

  // Walk sequencer and button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      lv_q     <= '0;
      pend_v_q <= 1'b0;
      pend_q   <= '0;
      accum_q  <= '0;
      fired_q  <= '0;
      ready_q  <= '0;
      cons_q   <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        phase_q[b] <= PH_IDLE;
        hold_q[b]  <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (tick_valid_i) begin
            lv_q    <= tick_levels_i;
            idx_q   <= '0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!walk_live) begin
            state_q <= ST_COMBO;
          end else if (step_ok) begin
            phase_q[sel] <= ph_n;
            hold_q[sel]  <= hold_n;
            fired_q[sel] <= fired_n;
            ready_q[sel] <= ready_n;
            cons_q[sel]  <= cons_n;
            accum_q      <= accum_n;
            idx_q        <= idx_q + 1'b1;
            if (ev_valid) begin
              pend_q   <= ev;
              pend_v_q <= 1'b1;
            end
          end
        end
        ST_COMBO: begin
          if (step_ok) begin
            if (ev_valid) begin
              for (int b = 0; b < BUTTONS; b++) begin
                if ((b < int'(used)) && acc_b[b]) cons_q[b] <= 1'b1;
              end
              accum_q  <= '0;
              pend_q   <= ev;
              pend_v_q <= 1'b1;
            end
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (push_ready_i) begin
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Only a held event ever goes to the queue
  a_push_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> pend_v_q)
    else $error("push without a held event");

  // The final push of a tick ends the tick with nothing held
  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && push_valid_o && push_ready_i) |=>
      (state_q == ST_IDLE && !pend_v_q))
    else $error("flush did not close the tick");

  // A combo event empties the accumulator
  a_combo_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMBO && ev_valid && step_ok) |=> (accum_q == '0))
    else $error("accumulator kept after combo");

  // The walk index never exceeds the number of buttons built
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (int'(idx_q) <= BUTTONS))
    else $error("walk index out of range");

endmodule

// File: design/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: event queue between front and back
// A short first-in first-out store of event words so the walker and the
// output side stall on their own.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  bpc_pkg::event_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output bpc_pkg::event_t pop_data_o
);
  import bpc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  event_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [NW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (int'(cnt_q) < QUEUE_DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= QUEUE_DEPTH)
    else $error("queue overfilled");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fill count missed a push");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push && cnt_q == NW'(1)) |=> !pop_valid_o)
    else $error("queue not empty after last pop");

endmodule

// File: design/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: event output stage
// Takes event words from the queue into an output register and presents
// them on the master stream until taken.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  bpc_pkg::event_t q_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bpc_pkg::event_t out_data_o
);
  import bpc_pkg::*;

  logic   out_v_q;
  event_t out_q;

  // Load when the register is empty or being taken
  assign q_pop_o     = q_valid_i && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (q_pop_o) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

endmodule
